// ===== rtl/drive_command_mode_arbiter_defines.svh =====
// Assertion macros for the drive command mode arbiter
`ifndef DRIVE_COMMAND_MODE_ARBITER_DEFINES_SVH
`define DRIVE_COMMAND_MODE_ARBITER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, idle while rst_n is low
`define DCMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcma assertion failed");
// next-cycle implication
`define DCMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcma assertion failed");
`else
`define DCMA_ASSERT_NOW(lbl, ante, cons)
`define DCMA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/dcma_pkg.sv =====
// Types, codes and helpers shared by the drive command mode arbiter
`timescale 1ns / 1ps

package dcma_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_EMERG   = 3'd1;
  localparam logic [2:0] KIND_TRAFFIC = 3'd2;
  localparam logic [2:0] KIND_WAYPT   = 3'd3;
  localparam logic [2:0] KIND_BUTTON  = 3'd4;
  localparam logic [2:0] KIND_TELEOP  = 3'd5;

  localparam logic [1:0] MODE_DRIVE  = 2'd0;
  localparam logic [1:0] MODE_ESTOP  = 2'd1;
  localparam logic [1:0] MODE_TSTOP  = 2'd2;
  localparam logic [1:0] MODE_MANUAL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_REV_TICKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TELEOP_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYPT_LIMIT  = 3'd4;

  localparam logic [7:0] RST_REV_TICKS    = 8'd5;
  localparam logic [7:0] RST_LOCKOUT      = 8'd10;
  localparam logic [7:0] RST_REV_SPEED    = 8'd20;
  localparam logic [7:0] RST_TELEOP_LIMIT = 8'd100;
  localparam logic [7:0] RST_WAYPT_LIMIT  = 8'd255;

  localparam logic [7:0] AGE_SAT = 8'hFF;

  typedef struct packed {
    logic [7:0] reverse_pulse_ticks;
    logic [7:0] toggle_lockout_ticks;
    logic [7:0] reverse_speed;
    logic [7:0] teleop_speed_limit;
    logic [7:0] waypoint_speed_limit;
  } cfg_t;

  // symmetric clamp of a 16-bit command to +/- lim
  function automatic logic signed [8:0] clamp_sym(input logic signed [15:0] v,
                                                  input logic [7:0] lim);
    logic signed [16:0] v17;
    logic signed [16:0] l17;
    logic signed [8:0]  res;
    v17 = {v[15], v};
    l17 = {9'd0, lim};
    if (v17 > l17) begin
      res = {1'b0, lim};
    end else if (v17 < -l17) begin
      res = -$signed({1'b0, lim});
    end else begin
      res = v[8:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/dcma_channels.sv =====
// Channel interfaces: input items, result items and register writes
`timescale 1ns / 1ps

interface dcma_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic               flag_value;
  logic               toggle_button;
  logic signed [15:0] speed_cmd;
  logic signed [15:0] steer_cmd;

  modport source (output valid, kind, flag_value, toggle_button, speed_cmd, steer_cmd,
                  input ready);
  modport sink (input valid, kind, flag_value, toggle_button, speed_cmd, steer_cmd,
                output ready);
endinterface

interface dcma_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         drive_mode;
  logic signed [8:0]  speed_out;
  logic signed [15:0] steer_out;
  logic               reversing;

  modport source (output valid, drive_mode, speed_out, steer_out, reversing,
                  input ready);
  modport sink (input valid, drive_mode, speed_out, steer_out, reversing,
                output ready);
endinterface

interface dcma_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/dcma_cfg_regs.sv =====
// Configuration register file of the drive command mode arbiter
`timescale 1ns / 1ps

module dcma_cfg_regs
  import dcma_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dcma_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_REV_TICKS:    cfg_nxt.reverse_pulse_ticks  = cfg_ch.data;
        CFG_LOCKOUT:      cfg_nxt.toggle_lockout_ticks = cfg_ch.data;
        CFG_REV_SPEED:    cfg_nxt.reverse_speed        = cfg_ch.data;
        CFG_TELEOP_LIMIT: cfg_nxt.teleop_speed_limit   = cfg_ch.data;
        CFG_WAYPT_LIMIT:  cfg_nxt.waypoint_speed_limit = cfg_ch.data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reverse_pulse_ticks  <= RST_REV_TICKS;
      cfg_r.toggle_lockout_ticks <= RST_LOCKOUT;
      cfg_r.reverse_speed        <= RST_REV_SPEED;
      cfg_r.teleop_speed_limit   <= RST_TELEOP_LIMIT;
      cfg_r.waypoint_speed_limit <= RST_WAYPT_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/drive_command_mode_arbiter.sv =====
// Drive command mode arbiter: one event or tick per cycle while in_ch.ready is high, one
// result per tick. Every input transfer is applied to the arbiter state in the cycle it
// is taken, so a new item is accepted every cycle in which in_ch.ready is high. A tick
// yields its result in the output register on the next cycle; in_ch.ready drops only
// while that register holds a result the sink has not taken. Events other than ticks
// produce no result. Register writes are taken every cycle and act from the next one.
`timescale 1ns / 1ps

`include "drive_command_mode_arbiter_defines.svh"

module drive_command_mode_arbiter
  import dcma_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dcma_in_if.sink     in_ch,
  dcma_out_if.source  out_ch,
  dcma_cfg_if.sink    cfg_ch
);

  cfg_t cfg;

  dcma_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  logic [1:0]         mode_r, mode_nxt;
  logic               emerg_r, emerg_nxt;
  logic               traffic_r, traffic_nxt;
  logic signed [8:0]  auto_speed_r, auto_speed_nxt;
  logic signed [15:0] auto_steer_r, auto_steer_nxt;
  logic signed [8:0]  man_speed_r, man_speed_nxt;
  logic signed [15:0] man_steer_r, man_steer_nxt;
  logic               pend_r, pend_nxt;
  logic [7:0]         pulse_age_r, pulse_age_nxt;
  logic [7:0]         toggle_age_r, toggle_age_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_mode_r, out_mode_nxt;
  logic signed [8:0]  out_speed_r, out_speed_nxt;
  logic signed [15:0] out_steer_r, out_steer_nxt;
  logic               out_rev_r, out_rev_nxt;

  logic               in_xfer;
  logic [1:0]         tick_mode;
  logic               pulse_run;
  logic               tick_rev;

  assign in_ch.ready       = out_ch.ready || !out_valid_r;
  assign in_xfer           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.drive_mode = out_mode_r;
  assign out_ch.speed_out  = out_speed_r;
  assign out_ch.steer_out  = out_steer_r;
  assign out_ch.reversing  = out_rev_r;

  always_comb begin
    if (mode_r == MODE_MANUAL) begin
      tick_mode = MODE_MANUAL;
    end else if (emerg_r) begin
      tick_mode = MODE_ESTOP;
    end else if (traffic_r) begin
      tick_mode = MODE_TSTOP;
    end else begin
      tick_mode = MODE_DRIVE;
    end
    pulse_run = pend_r && (pulse_age_r < cfg.reverse_pulse_ticks);
    tick_rev  = pulse_run && (tick_mode == MODE_ESTOP);
  end

  always_comb begin
    mode_nxt       = mode_r;
    emerg_nxt      = emerg_r;
    traffic_nxt    = traffic_r;
    auto_speed_nxt = auto_speed_r;
    auto_steer_nxt = auto_steer_r;
    man_speed_nxt  = man_speed_r;
    man_steer_nxt  = man_steer_r;
    pend_nxt       = pend_r;
    pulse_age_nxt  = pulse_age_r;
    toggle_age_nxt = toggle_age_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_mode_nxt   = out_mode_r;
    out_speed_nxt  = out_speed_r;
    out_steer_nxt  = out_steer_r;
    out_rev_nxt    = out_rev_r;
    if (in_xfer) begin
      case (in_ch.kind)
        KIND_TICK: begin
          mode_nxt      = tick_mode;
          pend_nxt      = pulse_run;
          out_valid_nxt = 1'b1;
          out_mode_nxt  = tick_mode;
          out_rev_nxt   = tick_rev;
          case (tick_mode)
            MODE_ESTOP: begin
              out_speed_nxt = tick_rev ? -$signed({1'b0, cfg.reverse_speed}) : 9'sd0;
              out_steer_nxt = 16'sd0;
            end
            MODE_MANUAL: begin
              out_speed_nxt = man_speed_r;
              out_steer_nxt = man_steer_r;
            end
            MODE_DRIVE: begin
              out_speed_nxt = auto_speed_r;
              out_steer_nxt = auto_steer_r;
            end
            default: begin
              out_speed_nxt = 9'sd0;
              out_steer_nxt = 16'sd0;
            end
          endcase
          pulse_age_nxt  = (pulse_age_r == AGE_SAT) ? pulse_age_r : pulse_age_r + 8'd1;
          toggle_age_nxt = (toggle_age_r == AGE_SAT) ? toggle_age_r : toggle_age_r + 8'd1;
        end
        KIND_EMERG: begin
          if (in_ch.flag_value && !emerg_r) begin
            pend_nxt      = 1'b1;
            pulse_age_nxt = 8'd0;
          end
          emerg_nxt = in_ch.flag_value;
        end
        KIND_TRAFFIC: begin
          traffic_nxt = in_ch.flag_value;
        end
        KIND_WAYPT: begin
          auto_speed_nxt = clamp_sym(in_ch.speed_cmd, cfg.waypoint_speed_limit);
          auto_steer_nxt = in_ch.steer_cmd;
        end
        KIND_BUTTON: begin
          if (in_ch.toggle_button && (toggle_age_r >= cfg.toggle_lockout_ticks)) begin
            mode_nxt       = (mode_r == MODE_MANUAL) ? MODE_DRIVE : MODE_MANUAL;
            toggle_age_nxt = 8'd0;
          end
        end
        KIND_TELEOP: begin
          man_speed_nxt = clamp_sym(in_ch.speed_cmd, cfg.teleop_speed_limit);
          man_steer_nxt = in_ch.steer_cmd;
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_MANUAL;
      emerg_r      <= 1'b0;
      traffic_r    <= 1'b0;
      auto_speed_r <= 9'sd0;
      auto_steer_r <= 16'sd0;
      man_speed_r  <= 9'sd0;
      man_steer_r  <= 16'sd0;
      pend_r       <= 1'b0;
      pulse_age_r  <= AGE_SAT;
      toggle_age_r <= AGE_SAT;
      out_valid_r  <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      emerg_r      <= emerg_nxt;
      traffic_r    <= traffic_nxt;
      auto_speed_r <= auto_speed_nxt;
      auto_steer_r <= auto_steer_nxt;
      man_speed_r  <= man_speed_nxt;
      man_steer_r  <= man_steer_nxt;
      pend_r       <= pend_nxt;
      pulse_age_r  <= pulse_age_nxt;
      toggle_age_r <= toggle_age_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mode_r  <= out_mode_nxt;
    out_speed_r <= out_speed_nxt;
    out_steer_r <= out_steer_nxt;
    out_rev_r   <= out_rev_nxt;
  end

  `DCMA_ASSERT_NOW(a_rev_only_estop, out_valid_r && out_rev_r, out_mode_r == MODE_ESTOP)
  `DCMA_ASSERT_NOW(a_stop_no_steer,
                   out_valid_r && (out_mode_r == MODE_ESTOP || out_mode_r == MODE_TSTOP),
                   out_steer_r == 16'sd0)
  `DCMA_ASSERT_NOW(a_fresh_pulse_pending, pulse_age_r == 8'd0, pend_r)
  `DCMA_ASSERT_NEXT(a_tick_gives_result, in_xfer && in_ch.kind == KIND_TICK, out_valid_r)

endmodule
